[hdl/rtm_pkg.sv]
// Shared types and constants for the radix tree map get/set core.
`default_nettype none
package rtm_pkg;

  localparam int NODE_POOL_DEF  = 256;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SLOTS          = 256;
  localparam int SLICE_BITS     = 8;
  localparam int INDEX_BITS     = 32;
  localparam int DATA_BITS      = 32;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_NO_NODES = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GROW,
    S_RD,
    S_CHK,
    S_ALLOC
  } state_t;

endpackage
`default_nettype wire

[hdl/radix_tree_map_get_set_core.sv]
// Radix tree map core: four-level, 8-bit-slice sparse map with node pool.
// Walk: each tree level walked is a registered memory read (S_RD), then a check
// (S_CHK); nodes are grown in S_GROW and slots written in S_ALLOC, then the result strobe.
// Throughput: one request at a time; busy is high while a request is walked.
// Reset: synchronous, empties the tree; node mark rows are cleared as allocated.
`default_nettype none
module radix_tree_map_get_set_core #(
  parameter int NODE_POOL  = rtm_pkg::NODE_POOL_DEF,
  parameter int VALUE_BITS = rtm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_operation,
  input  wire logic [rtm_pkg::INDEX_BITS-1:0]   in_index,
  input  wire logic [rtm_pkg::DATA_BITS-1:0]    in_value,
  output logic                                  out_valid,
  output logic [rtm_pkg::DATA_BITS-1:0]         out_read_value,
  output logic                                  out_status
);

  localparam int NB  = $clog2(NODE_POOL);
  localparam int NFW = $clog2(NODE_POOL + 1);
  localparam int CW  = NFW + 1;
  localparam int VW  = (VALUE_BITS < rtm_pkg::DATA_BITS) ? VALUE_BITS : rtm_pkg::DATA_BITS;
  localparam int SW  = (VW > NB) ? VW : NB;
  localparam int SB  = rtm_pkg::SLICE_BITS;
  localparam int AW  = NB + SB;
  localparam int SL  = rtm_pkg::SLOTS;

  function automatic logic [2:0] height_of(input logic [rtm_pkg::INDEX_BITS-1:0] idx);
    logic [2:0] h;
    if (idx[31:8] == 24'd0) h = 3'd1;
    else if (idx[31:16] == 16'd0) h = 3'd2;
    else if (idx[31:24] == 8'd0) h = 3'd3;
    else h = 3'd4;
    return h;
  endfunction

  function automatic logic [SB-1:0] slice_of(input logic [rtm_pkg::INDEX_BITS-1:0] idx,
                                             input logic [1:0] sel);
    logic [SB-1:0] s;
    case (sel)
      2'd0:    s = idx[7:0];
      2'd1:    s = idx[15:8];
      2'd2:    s = idx[23:16];
      default: s = idx[31:24];
    endcase
    return s;
  endfunction

  function automatic logic upper_zero(input logic [rtm_pkg::INDEX_BITS-1:0] idx,
                                      input logic [1:0] sel);
    logic z;
    case (sel)
      2'd0:    z = (idx == 32'd0);
      2'd1:    z = (idx[31:8] == 24'd0);
      2'd2:    z = (idx[31:16] == 16'd0);
      default: z = (idx[31:24] == 8'd0);
    endcase
    return z;
  endfunction

  rtm_pkg::state_t state_r, state_nxt;

  logic                            op_r, op_nxt;
  logic [rtm_pkg::INDEX_BITS-1:0]  idx_r, idx_nxt;
  logic [VW-1:0]                   val_r, val_nxt;
  logic [2:0]                      lvl_r, lvl_nxt;
  logic [NB-1:0]                   node_r, node_nxt;
  logic [SL-1:0]                   row_r, row_nxt;
  logic [NFW-1:0]                  next_free_r, next_free_nxt;
  logic [3:0]                      root_vld_r, root_vld_nxt;
  logic [NB-1:0]                   root_node_r [4];
  logic [NB-1:0]                   root_node_nxt [4];
  logic                            out_valid_r, out_valid_nxt;
  logic [rtm_pkg::DATA_BITS-1:0]   out_rv_r, out_rv_nxt;
  logic                            out_st_r, out_st_nxt;

  logic [SW-1:0]  store_mem [NODE_POOL*SL];
  logic [SL-1:0]  mark_mem  [NODE_POOL];
  logic [SW-1:0]  store_rdata_r;
  logic [SL-1:0]  mark_rdata_r;

  logic           rd_en;
  logic           store_we;
  logic           mark_we;
  logic [AW-1:0]  store_waddr;
  logic [NB-1:0]  mark_waddr;
  logic [SW-1:0]  store_wdata;
  logic [SL-1:0]  mark_wdata;

  logic           accept;
  logic [2:0]     need_in;
  logic [2:0]     need_r;
  logic [2:0]     h_c;
  logic [2:0]     lvl_dec;
  logic [2:0]     lvl_dec2;
  logic [SB-1:0]  sl_c;
  logic           bit_c;
  logic [NB-1:0]  free_node;
  logic [3:0]     cost_c;
  logic           grow_c;
  logic           pre_fail;
  logic           walk_fail;
  logic [1:0]     need_sel;
  logic [1:0]     h_sel;

  assign accept    = start && (state_r == rtm_pkg::S_IDLE);
  assign busy      = (state_r != rtm_pkg::S_IDLE);
  assign need_in   = height_of(in_index);
  assign need_r    = height_of(idx_r);
  assign need_sel  = 2'(need_in - 3'd1);
  assign h_sel     = 2'(h_c - 3'd1);
  assign lvl_dec   = lvl_r - 3'd1;
  assign lvl_dec2  = lvl_r - 3'd2;
  assign sl_c      = slice_of(idx_r, lvl_dec[1:0]);
  assign bit_c     = mark_rdata_r[sl_c];
  assign free_node = next_free_r[NB-1:0];

  always_comb begin
    if (root_vld_r[3]) h_c = 3'd4;
    else if (root_vld_r[2]) h_c = 3'd3;
    else if (root_vld_r[1]) h_c = 3'd2;
    else if (root_vld_r[0]) h_c = 3'd1;
    else h_c = 3'd0;
  end

  assign grow_c   = (h_c != 3'd0) && (h_c < need_in);
  assign cost_c   = (h_c == 3'd0) ? {1'b0, need_in}
                  : ({1'b0, need_in} - {1'b0, h_c}) + ({1'b0, need_in} - 4'd1);
  assign pre_fail = ((h_c == 3'd0) || grow_c)
                  && ((CW'(next_free_r) + CW'(cost_c)) > CW'(NODE_POOL));
  assign walk_fail = (CW'(next_free_r) + CW'(lvl_dec)) > CW'(NODE_POOL);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtm_pkg::S_IDLE: begin
        if (accept) begin
          if (in_operation == rtm_pkg::OP_WRITE) begin
            if (pre_fail) state_nxt = rtm_pkg::S_IDLE;
            else if (h_c == 3'd0) state_nxt = rtm_pkg::S_ALLOC;
            else if (grow_c) state_nxt = rtm_pkg::S_GROW;
            else state_nxt = rtm_pkg::S_RD;
          end else if (root_vld_r[need_sel]) begin
            state_nxt = rtm_pkg::S_RD;
          end
        end
      end
      rtm_pkg::S_GROW: begin
        if (lvl_r == need_r) state_nxt = rtm_pkg::S_ALLOC;
      end
      rtm_pkg::S_RD: begin
        state_nxt = rtm_pkg::S_CHK;
      end
      rtm_pkg::S_CHK: begin
        if (op_r == rtm_pkg::OP_READ) begin
          if ((lvl_r == 3'd1) || !bit_c) state_nxt = rtm_pkg::S_IDLE;
          else state_nxt = rtm_pkg::S_RD;
        end else begin
          if (lvl_r == 3'd1) state_nxt = rtm_pkg::S_ALLOC;
          else if (bit_c) state_nxt = rtm_pkg::S_RD;
          else if (walk_fail) state_nxt = rtm_pkg::S_IDLE;
          else state_nxt = rtm_pkg::S_ALLOC;
        end
      end
      rtm_pkg::S_ALLOC: begin
        if (lvl_r == 3'd1) state_nxt = rtm_pkg::S_IDLE;
      end
      default: state_nxt = rtm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    lvl_nxt       = lvl_r;
    node_nxt      = node_r;
    row_nxt       = row_r;
    next_free_nxt = next_free_r;
    root_vld_nxt  = root_vld_r;
    root_node_nxt = root_node_r;
    out_valid_nxt = 1'b0;
    out_rv_nxt    = out_rv_r;
    out_st_nxt    = out_st_r;
    rd_en         = 1'b0;
    store_we      = 1'b0;
    mark_we       = 1'b0;
    store_waddr   = {node_r, sl_c};
    mark_waddr    = node_r;
    store_wdata   = SW'(val_r);
    mark_wdata    = row_r | (SL'(1) << sl_c);
    unique case (state_r)
      rtm_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt  = in_operation;
          idx_nxt = in_index;
          val_nxt = in_value[VW-1:0];
          if (in_operation == rtm_pkg::OP_WRITE) begin
            if (pre_fail) begin
              out_valid_nxt = 1'b1;
              out_rv_nxt    = '0;
              out_st_nxt    = rtm_pkg::ST_NO_NODES;
            end else if (h_c == 3'd0) begin
              root_vld_nxt[need_sel]  = 1'b1;
              root_node_nxt[need_sel] = free_node;
              next_free_nxt           = next_free_r + NFW'(1);
              node_nxt                = free_node;
              row_nxt                 = '0;
              lvl_nxt                 = need_in;
            end else if (grow_c) begin
              node_nxt = root_node_r[h_sel];
              lvl_nxt  = h_c + 3'd1;
            end else begin
              node_nxt = root_node_r[h_sel];
              lvl_nxt  = h_c;
            end
          end else if (root_vld_r[need_sel]) begin
            node_nxt = root_node_r[need_sel];
            lvl_nxt  = need_in;
          end else begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = '0;
            out_st_nxt    = rtm_pkg::ST_OK;
          end
        end
      end
      rtm_pkg::S_GROW: begin
        mark_we                      = 1'b1;
        mark_waddr                   = free_node;
        mark_wdata                   = SL'(1);
        store_we                     = 1'b1;
        store_waddr                  = {free_node, SB'(0)};
        store_wdata                  = SW'(node_r);
        root_vld_nxt[lvl_dec[1:0]]   = 1'b1;
        root_node_nxt[lvl_dec[1:0]]  = free_node;
        next_free_nxt                = next_free_r + NFW'(1);
        node_nxt                     = free_node;
        if (lvl_r == need_r) row_nxt = SL'(1);
        else lvl_nxt = lvl_r + 3'd1;
      end
      rtm_pkg::S_RD: begin
        rd_en = 1'b1;
      end
      rtm_pkg::S_CHK: begin
        if (op_r == rtm_pkg::OP_READ) begin
          if (lvl_r == 3'd1) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = bit_c ? rtm_pkg::DATA_BITS'(store_rdata_r[VW-1:0]) : '0;
            out_st_nxt    = rtm_pkg::ST_OK;
          end else if (!bit_c) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = '0;
            out_st_nxt    = rtm_pkg::ST_OK;
          end else begin
            node_nxt = store_rdata_r[NB-1:0];
            lvl_nxt  = lvl_dec;
          end
        end else begin
          if (lvl_r == 3'd1) begin
            row_nxt = mark_rdata_r;
          end else if (bit_c) begin
            node_nxt = store_rdata_r[NB-1:0];
            lvl_nxt  = lvl_dec;
          end else if (walk_fail) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = '0;
            out_st_nxt    = rtm_pkg::ST_NO_NODES;
          end else begin
            row_nxt = mark_rdata_r;
          end
        end
      end
      rtm_pkg::S_ALLOC: begin
        mark_we  = 1'b1;
        store_we = 1'b1;
        if (lvl_r == 3'd1) begin
          store_wdata   = SW'(val_r);
          out_valid_nxt = 1'b1;
          out_rv_nxt    = '0;
          out_st_nxt    = rtm_pkg::ST_OK;
        end else begin
          store_wdata   = SW'(free_node);
          next_free_nxt = next_free_r + NFW'(1);
          if (upper_zero(idx_r, lvl_dec[1:0])) begin
            root_vld_nxt[lvl_dec2[1:0]]  = 1'b1;
            root_node_nxt[lvl_dec2[1:0]] = free_node;
          end
          node_nxt = free_node;
          row_nxt  = '0;
          lvl_nxt  = lvl_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtm_pkg::S_IDLE;
      next_free_r <= '0;
      root_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      root_vld_r  <= root_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    lvl_r       <= lvl_nxt;
    node_r      <= node_nxt;
    row_r       <= row_nxt;
    root_node_r <= root_node_nxt;
    out_rv_r    <= out_rv_nxt;
    out_st_r    <= out_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= store_wdata;
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    if (rd_en) begin
      store_rdata_r <= store_mem[{node_r, sl_c}];
      mark_rdata_r  <= mark_mem[node_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_status     = out_st_r;

endmodule
`default_nettype wire

[hdl/rtm_checker.sv]
// Port-level checks for the radix tree map core, bound to the core module.
`default_nettype none
module rtm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_valid,
  input wire logic [rtm_pkg::DATA_BITS-1:0]  out_read_value,
  input wire logic                           out_status
);

  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("request neither answered nor in progress");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == rtm_pkg::ST_NO_NODES)) |-> (out_read_value == '0))
    else $error("failed write returned nonzero value");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("request ended without a result");

endmodule

bind radix_tree_map_get_set_core rtm_checker u_rtm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_read_value (out_read_value),
  .out_status     (out_status)
);
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the radix tree map core: directed and random get/set requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL          = rtm_pkg::NODE_POOL_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HISTORY_DEPTH = 512;

  typedef struct {
    logic [rtm_pkg::DATA_BITS-1:0] read_value;
    logic                          status;
  } map_answer_t;

  typedef struct {
    logic valid;
    int   node;
  } root_ref_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_operation;
  logic [rtm_pkg::INDEX_BITS-1:0] in_index;
  logic [rtm_pkg::DATA_BITS-1:0]  in_value;
  logic                           out_valid;
  logic [rtm_pkg::DATA_BITS-1:0]  out_read_value;
  logic                           out_status;

  radix_tree_map_get_set_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_index      (in_index),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_status    (out_status)
  );

  logic [rtm_pkg::DATA_BITS-1:0]  slot_word [POOL][rtm_pkg::SLOTS];
  logic [rtm_pkg::SLOTS-1:0]      slot_marks [POOL];
  root_ref_t                      level_root [1:4];
  int                             nodes_handed;

  map_answer_t                    answers_due [$];
  logic [rtm_pkg::INDEX_BITS-1:0] written_idx [$];
  logic [7:0]                     top_bytes [4];
  logic [7:0]                     mid_bytes [4];
  logic [7:0]                     low_bytes [4];
  logic                           last_status;
  int                             sender_idle_pct;
  int                             fail_count;
  int                             cycle_count;
  int                             read_count;
  int                             write_count;
  int                             refused_count;

  function automatic int levels_for(logic [rtm_pkg::INDEX_BITS-1:0] idx);
    if (idx < 32'h100) return 1;
    if (idx < 32'h10000) return 2;
    if (idx < 32'h1000000) return 3;
    return 4;
  endfunction

  function automatic int tree_levels();
    int k;
    for (k = 4; k >= 1; k--) begin
      if (level_root[k].valid) return k;
    end
    return 0;
  endfunction

  function automatic logic [7:0] slice_at(logic [rtm_pkg::INDEX_BITS-1:0] idx, int k);
    return idx[8*k +: 8];
  endfunction

  function automatic int grab_node();
    int n;
    n = nodes_handed;
    slot_marks[n] = '0;
    nodes_handed++;
    return n;
  endfunction

  function automatic logic [rtm_pkg::DATA_BITS-1:0] map_lookup(
      logic [rtm_pkg::INDEX_BITS-1:0] idx);
    int         k;
    int         node;
    logic [7:0] b;
    k = levels_for(idx);
    if (!level_root[k].valid) return '0;
    node = level_root[k].node;
    while (k > 1) begin
      b = slice_at(idx, k - 1);
      if (!slot_marks[node][b]) return '0;
      node = slot_word[node][b][7:0];
      k--;
    end
    b = slice_at(idx, 0);
    return slot_marks[node][b] ? slot_word[node][b] : '0;
  endfunction

  function automatic logic map_store(logic [rtm_pkg::INDEX_BITS-1:0] idx,
                                     logic [rtm_pkg::DATA_BITS-1:0] val);
    int         h;
    int         need;
    int         cost;
    int         k;
    int         node;
    int         c;
    int         prev;
    logic [7:0] b;
    h    = tree_levels();
    need = levels_for(idx);
    cost = 0;
    if (h == 0) begin
      cost = need;
    end else if (h < need) begin
      cost = (need - h) + (need - 1);
    end else begin
      node = level_root[h].node;
      k = h;
      while (k > 1) begin
        b = slice_at(idx, k - 1);
        if (!slot_marks[node][b]) begin
          cost = k - 1;
          break;
        end
        node = slot_word[node][b][7:0];
        k--;
      end
    end
    if (nodes_handed + cost > POOL) return rtm_pkg::ST_NO_NODES;

    if (h == 0) begin
      c = grab_node();
      level_root[need] = '{1'b1, c};
      h = need;
    end else if (h < need) begin
      prev = level_root[h].node;
      for (k = h + 1; k <= need; k++) begin
        c = grab_node();
        slot_marks[c][0] = 1'b1;
        slot_word[c][0]  = prev;
        level_root[k]    = '{1'b1, c};
        prev = c;
      end
      h = need;
    end

    node = level_root[h].node;
    for (k = h; k > 1; k--) begin
      b = slice_at(idx, k - 1);
      if (!slot_marks[node][b]) begin
        c = grab_node();
        slot_marks[node][b] = 1'b1;
        slot_word[node][b]  = c;
        if ((idx >> (8 * (k - 1))) == 0) level_root[k - 1] = '{1'b1, c};
      end
      node = slot_word[node][b][7:0];
    end
    b = slice_at(idx, 0);
    slot_marks[node][b] = 1'b1;
    slot_word[node][b]  = val;
    return rtm_pkg::ST_OK;
  endfunction

  function automatic logic [rtm_pkg::INDEX_BITS-1:0] hot_index();
    return {top_bytes[$urandom_range(3)], mid_bytes[$urandom_range(3)],
            low_bytes[$urandom_range(3)], 8'($urandom)};
  endfunction

  function automatic logic [rtm_pkg::DATA_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 12) return '1;
    return $urandom;
  endfunction

  task automatic send_request(logic op, logic [rtm_pkg::INDEX_BITS-1:0] idx,
                              logic [rtm_pkg::DATA_BITS-1:0] val);
    map_answer_t due;
    @(negedge clk);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_index     <= idx;
    in_value     <= val;
    do @(posedge clk); while (busy);
    if (op == rtm_pkg::OP_WRITE) begin
      due.read_value = '0;
      due.status     = map_store(idx, val);
      write_count++;
      if (due.status == rtm_pkg::ST_NO_NODES) begin
        refused_count++;
      end else begin
        written_idx.push_back(idx);
        if (written_idx.size() > HISTORY_DEPTH) void'(written_idx.pop_front());
      end
    end else begin
      due.read_value = map_lookup(idx);
      due.status     = rtm_pkg::ST_OK;
      read_count++;
    end
    last_status = due.status;
    answers_due.push_back(due);
  endtask

  task automatic test_empty_map();
    sender_idle_pct = 0;
    send_request(rtm_pkg::OP_READ, 32'h0000_0000, '0);
    send_request(rtm_pkg::OP_READ, 32'hFFFF_FFFF, '1);
  endtask

  task automatic test_tree_growth();
    sender_idle_pct = 0;
    send_request(rtm_pkg::OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(rtm_pkg::OP_READ,  32'h0000_0000, '0);
    send_request(rtm_pkg::OP_READ,  32'h0000_00FF, '0);
    send_request(rtm_pkg::OP_WRITE, 32'h0000_1234, 32'hA5A5_A5A5);
    send_request(rtm_pkg::OP_READ,  32'h0000_0000, '0);
    send_request(rtm_pkg::OP_READ,  32'h0000_1234, '0);
    send_request(rtm_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(rtm_pkg::OP_READ,  32'hFFFF_FFFF, '0);
    send_request(rtm_pkg::OP_READ,  32'h0000_1234, '0);
    send_request(rtm_pkg::OP_READ,  32'h00FF_FFFF, '0);
    send_request(rtm_pkg::OP_WRITE, 32'h00FF_FFFF, 32'h8000_0000);
    send_request(rtm_pkg::OP_WRITE, 32'h0100_0000, 32'h7FFF_FFFF);
    send_request(rtm_pkg::OP_READ,  32'h00FF_FFFF, '0);
    send_request(rtm_pkg::OP_READ,  32'h0100_0000, '0);
  endtask

  task automatic test_delete_and_zero();
    sender_idle_pct = 0;
    send_request(rtm_pkg::OP_WRITE, 32'h0000_1234, '0);
    send_request(rtm_pkg::OP_READ,  32'h0000_1234, '0);
    send_request(rtm_pkg::OP_WRITE, 32'h0001_0000, '0);
    send_request(rtm_pkg::OP_READ,  32'h0001_0000, '0);
    send_request(rtm_pkg::OP_WRITE, 32'h0000_00FF, 32'h0000_FFFF);
    send_request(rtm_pkg::OP_READ,  32'h0000_00FF, '0);
    send_request(rtm_pkg::OP_WRITE, 32'h0000_0000, 32'h1234_5678);
    send_request(rtm_pkg::OP_READ,  32'h0000_0000, '0);
    send_request(rtm_pkg::OP_READ,  32'h0000_0100, '0);
  endtask

  task automatic test_random_traffic(int count, int idle_pct);
    int r;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40)
        send_request(rtm_pkg::OP_WRITE, hot_index(), pick_value());
      else if (r < 75 && written_idx.size() > 0)
        send_request(rtm_pkg::OP_READ, written_idx[$urandom_range(written_idx.size() - 1)],
                     $urandom);
      else if (r < 92)
        send_request(rtm_pkg::OP_READ, hot_index(), $urandom);
      else if (r < 98)
        send_request(rtm_pkg::OP_READ, $urandom, $urandom);
      else
        send_request(rtm_pkg::OP_WRITE, $urandom, pick_value());
    end
  endtask

  task automatic test_pool_exhaustion();
    logic [rtm_pkg::INDEX_BITS-1:0] refused [$];
    logic [rtm_pkg::INDEX_BITS-1:0] idx;
    int                             tries;
    sender_idle_pct = 15;
    tries = 0;
    while (refused.size() < 6 && tries < 400) begin
      idx = ($urandom_range(3) == 0) ? hot_index() : $urandom;
      send_request(rtm_pkg::OP_WRITE, idx, pick_value());
      if (last_status == rtm_pkg::ST_NO_NODES) refused.push_back(idx);
      tries++;
    end
    foreach (refused[i]) send_request(rtm_pkg::OP_READ, refused[i], '0);
    repeat (40) begin
      send_request(rtm_pkg::OP_WRITE, written_idx[$urandom_range(written_idx.size() - 1)],
                   pick_value());
      send_request(rtm_pkg::OP_READ, written_idx[$urandom_range(written_idx.size() - 1)],
                   '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    map_answer_t due;
    if (rst_n && out_valid === 1'b1) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual read_value %h status %0b",
                 $time, out_read_value, out_status);
        fail_count++;
      end else begin
        due = answers_due.pop_front();
        if (out_read_value !== due.read_value) begin
          $display("%0t: read_value mismatch: expected %h, actual %h",
                   $time, due.read_value, out_read_value);
          fail_count++;
        end
        if (out_status !== due.status) begin
          $display("%0t: status mismatch: expected %0b, actual %0b",
                   $time, due.status, out_status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = rtm_pkg::OP_READ;
    in_index        = '0;
    in_value        = '0;
    last_status     = rtm_pkg::ST_OK;
    sender_idle_pct = 0;
    fail_count      = 0;
    cycle_count     = 0;
    read_count      = 0;
    write_count     = 0;
    refused_count   = 0;
    nodes_handed    = 0;
    for (int n = 0; n < POOL; n++) slot_marks[n] = '0;
    for (int k = 1; k <= 4; k++) level_root[k] = '{1'b0, 0};
    top_bytes = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    mid_bytes = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    low_bytes = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_map();
    test_tree_growth();
    test_delete_and_zero();
    test_random_traffic(550, 0);
    test_random_traffic(550, 82);
    test_random_traffic(550, 15);
    test_pool_exhaustion();

    @(negedge clk);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d reads and %0d writes, %0d writes refused for lack of free nodes",
             read_count, write_count, refused_count);
    $display("%0d of %0d tree nodes handed out, %0d mismatches",
             nodes_handed, POOL, fail_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
hdl/rtm_pkg.sv
hdl/radix_tree_map_get_set_core.sv
hdl/rtm_checker.sv
sim/testbench.sv
